// ===== rtl/bots_pkg.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport sequencer package
// Shared types and limits for the host-side bulk-only transport sequencer.
// ----------------------------------------------------------------------------
package bots_pkg;

  localparam int unsigned MaxPacketBytes = 64;
  localparam int unsigned MaxStages      = 255;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned InTdataW  = 8;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 64;

  typedef struct packed {
    logic [6:0] device_address;
    logic [3:0] out_endpoint;
    logic [3:0] in_endpoint;
    logic [7:0] data_stages;
    logic [6:0] stage_bytes;
    logic       direction_in;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] answer;
  } event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        recovery_req;
    logic [13:0] rx_store_offset;
    logic [1:0]  rx_store_kind;
    logic [13:0] buffer_offset;
    logic [6:0]  byte_count;
    logic [1:0]  phase;
    logic [6:0]  target_address;
    logic [3:0]  endpoint;
    logic [1:0]  token_pid;
    logic [1:0]  action;
  } result_t;

endpackage

// ===== rtl/bots_cfg.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport configuration registers
// Holds the device address, endpoints and transfer shape written by software.
// ----------------------------------------------------------------------------
module bots_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bots_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bots_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bots_pkg::cfg_t               cfg_o
);

  localparam logic [bots_pkg::CfgIdxW-1:0] RegDevAddr  = 3'd0;
  localparam logic [bots_pkg::CfgIdxW-1:0] RegOutEp    = 3'd1;
  localparam logic [bots_pkg::CfgIdxW-1:0] RegInEp     = 3'd2;
  localparam logic [bots_pkg::CfgIdxW-1:0] RegStages   = 3'd3;
  localparam logic [bots_pkg::CfgIdxW-1:0] RegStageLen = 3'd4;
  localparam logic [bots_pkg::CfgIdxW-1:0] RegDirIn    = 3'd5;

  bots_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDevAddr:  cfg_d.device_address = cfg_wdata_i[6:0];
        RegOutEp:    cfg_d.out_endpoint   = cfg_wdata_i[3:0];
        RegInEp:     cfg_d.in_endpoint    = cfg_wdata_i[3:0];
        RegStages:   cfg_d.data_stages    = cfg_wdata_i[7:0];
        RegStageLen: cfg_d.stage_bytes    = cfg_wdata_i[6:0];
        RegDirIn:    cfg_d.direction_in   = cfg_wdata_i[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bots_in_reg.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport input register
// Captures one event transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module bots_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bots_pkg::event_t  event_i,
  output logic              valid_o,
  input  logic              take_i,
  output bots_pkg::event_t  event_o
);

  logic             valid_q;
  bots_pkg::event_t event_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      event_q <= event_i;
    end
  end

  assign valid_o = valid_q;
  assign event_o = event_q;

endmodule

// ===== rtl/bots_core.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport sequencing core
// Holds the transfer phase, OUT toggle, stage count and buffer offset, and
// works out the next packet and the result for one event combinationally.
// ----------------------------------------------------------------------------
module bots_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bots_pkg::cfg_t    cfg_i,
  input  logic              fire_i,
  input  bots_pkg::event_t  event_i,
  output bots_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAIT_CBW, ST_WAIT_DATA, ST_WAIT_CSW, ST_COMPLETE, ST_ERROR
  } phase_state_e;

  typedef enum logic [1:0] {
    ISS_NONE, ISS_CBW, ISS_DATA, ISS_CSW
  } issue_e;

  localparam logic [1:0] ReqStart  = 2'd0;
  localparam logic [1:0] ReqAnswer = 2'd1;
  localparam logic [1:0] ReqDetach = 2'd2;

  localparam logic [2:0] AnsAck   = 3'd0;
  localparam logic [2:0] AnsStall = 3'd2;
  localparam logic [2:0] AnsData0 = 3'd3;
  localparam logic [2:0] AnsData1 = 3'd4;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActOut   = 2'd1;
  localparam logic [1:0] ActIn    = 2'd2;
  localparam logic [1:0] PidIn    = 2'd2;
  localparam logic [1:0] PhCbw    = 2'd0;
  localparam logic [1:0] PhData   = 2'd1;
  localparam logic [1:0] PhCsw    = 2'd2;
  localparam logic [1:0] RxData   = 2'd1;
  localparam logic [1:0] RxCsw    = 2'd2;
  localparam logic [1:0] StsBusy  = 2'd0;
  localparam logic [1:0] StsDone  = 2'd1;
  localparam logic [1:0] StsError = 2'd2;

  localparam logic [6:0] CbwBytes = 7'd31;
  localparam logic [6:0] CswBytes = 7'd13;

  phase_state_e phase_q, phase_d;
  logic         toggle_q, toggle_d;
  logic [7:0]   stages_q, stages_d;
  logic [13:0]  offset_q, offset_d;

  issue_e       issue;
  logic         advance;
  logic         data_ans;
  logic         waiting;
  logic [6:0]   stage_len;
  logic [7:0]   stages_sat;
  logic [13:0]  offset_adv;
  bots_pkg::result_t res;

  always_comb begin
    if (32'(cfg_i.stage_bytes) > bots_pkg::MaxPacketBytes) begin
      stage_len = 7'(bots_pkg::MaxPacketBytes);
    end else begin
      stage_len = cfg_i.stage_bytes;
    end
    if (32'(cfg_i.data_stages) > bots_pkg::MaxStages) begin
      stages_sat = 8'(bots_pkg::MaxStages);
    end else begin
      stages_sat = cfg_i.data_stages;
    end
  end

  assign offset_adv = offset_q + 14'(stage_len);
  assign data_ans   = (event_i.answer == AnsData0) || (event_i.answer == AnsData1);
  assign waiting    = (phase_q == ST_WAIT_CBW) || (phase_q == ST_WAIT_DATA) ||
                      (phase_q == ST_WAIT_CSW);

  always_comb begin
    phase_d  = phase_q;
    toggle_d = toggle_q;
    stages_d = stages_q;
    offset_d = offset_q;
    issue    = ISS_NONE;
    advance  = 1'b0;
    res      = '0;

    case (event_i.req_type)
      ReqStart: begin
        issue = ISS_CBW;
      end
      ReqAnswer: begin
        if (event_i.answer == AnsStall && waiting) begin
          res.recovery_req = 1'b1;
          issue = ISS_CBW;
        end else begin
          case (phase_q)
            ST_WAIT_CBW: begin
              if (event_i.answer == AnsAck) begin
                toggle_d = ~toggle_q;
                issue = (stages_q == 8'd0) ? ISS_CSW : ISS_DATA;
              end else begin
                issue = ISS_CBW;
              end
            end
            ST_WAIT_DATA: begin
              if (event_i.answer == AnsAck) begin
                if (cfg_i.direction_in) begin
                  issue = ISS_CBW;
                end else begin
                  toggle_d = ~toggle_q;
                  advance = 1'b1;
                end
              end else if (data_ans) begin
                if (cfg_i.direction_in) begin
                  res.rx_store_kind   = RxData;
                  res.rx_store_offset = offset_q;
                  advance = 1'b1;
                end else begin
                  issue = ISS_CBW;
                end
              end else begin
                issue = ISS_DATA;
              end
            end
            ST_WAIT_CSW: begin
              if (data_ans) begin
                res.rx_store_kind = RxCsw;
                phase_d = ST_COMPLETE;
              end else begin
                issue = ISS_CSW;
              end
            end
            default: begin
              issue = ISS_NONE;
            end
          endcase
        end
      end
      ReqDetach: begin
        phase_d = ST_ERROR;
      end
      default: begin
        issue = ISS_NONE;
      end
    endcase

    if (advance) begin
      offset_d = offset_adv;
      if (stages_q > 8'd1) begin
        stages_d = stages_q - 8'd1;
        issue = ISS_DATA;
      end else begin
        issue = ISS_CSW;
      end
    end

    case (issue)
      ISS_CBW: begin
        stages_d = stages_sat;
        offset_d = '0;
        phase_d  = ST_WAIT_CBW;
        res.action         = ActOut;
        res.token_pid      = {1'b0, toggle_d};
        res.endpoint       = cfg_i.out_endpoint;
        res.target_address = cfg_i.device_address;
        res.phase          = PhCbw;
        res.byte_count     = CbwBytes;
      end
      ISS_DATA: begin
        phase_d = ST_WAIT_DATA;
        if (cfg_i.direction_in) begin
          res.action    = ActIn;
          res.token_pid = PidIn;
          res.endpoint  = cfg_i.in_endpoint;
        end else begin
          res.action    = ActOut;
          res.token_pid = {1'b0, toggle_d};
          res.endpoint  = cfg_i.out_endpoint;
        end
        res.target_address = cfg_i.device_address;
        res.phase          = PhData;
        res.byte_count     = stage_len;
        res.buffer_offset  = offset_d;
      end
      ISS_CSW: begin
        phase_d = ST_WAIT_CSW;
        res.action         = ActIn;
        res.token_pid      = PidIn;
        res.endpoint       = cfg_i.in_endpoint;
        res.target_address = cfg_i.device_address;
        res.phase          = PhCsw;
        res.byte_count     = CswBytes;
      end
      default: begin
        res.action = ActNone;
      end
    endcase

    case (phase_d)
      ST_COMPLETE: res.status = StsDone;
      ST_ERROR:    res.status = StsError;
      default:     res.status = StsBusy;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ST_IDLE;
      toggle_q <= 1'b0;
      stages_q <= '0;
      offset_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      toggle_q <= toggle_d;
      stages_q <= stages_d;
      offset_q <= offset_d;
    end
  end

  assign result_o = res;

`ifndef NO_ASSERTIONS
  a_recovery_restarts_cbw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.recovery_req |=> phase_q == ST_WAIT_CBW)
    else $error("reset recovery did not restart at the CBW");

  a_rx_data_keeps_going: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.rx_store_kind == RxData |=>
      phase_q == ST_WAIT_DATA || phase_q == ST_WAIT_CSW)
    else $error("data copy did not lead to a data or CSW stage");

  a_toggle_only_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(toggle_q) && $stable(phase_q))
    else $error("sequencer state moved without an event");

  a_idle_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ST_IDLE |-> stages_q == 8'd0 && offset_q == 14'd0)
    else $error("idle phase with stale stage count or offset");
`endif

endmodule

// ===== rtl/bots_out_reg.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport result register
// Holds one result transfer until the downstream side takes it.
// ----------------------------------------------------------------------------
module bots_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bots_pkg::result_t  result_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               take_i,
  output bots_pkg::result_t  result_o
);

  logic              valid_q;
  bots_pkg::result_t result_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/bulk_only_transport_sequencer.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport sequencer
// Host-side sequencer for mass-storage bulk-only transfers: CBW, data stages
// and CSW, driven by start, handshake-answer and detach events.
//
// Channel   Direction  Payload
// s_axis    in         tdata: answer[2:0]; tuser: req_type[1:0]
// m_axis    out        tdata: 57 result bits, see port comment
// cfg       in         write enable, register index, write data
//
// Each event transfer gives exactly one result transfer, passing through the
// input register and then the result register, with the core combinational
// between them. One event is taken every cycle while m_axis does not stall.
// Reset returns to idle with toggle DATA0, no stages and offset zero.
// A stall on m_axis holds the result register, then the input register.
// ----------------------------------------------------------------------------
module bulk_only_transport_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // answer[2:0], zeros above
  input  logic [bots_pkg::InTdataW-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [bots_pkg::InTuserW-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // action[1:0], token_pid[3:2], endpoint[7:4], target_address[14:8],
  // phase[16:15], byte_count[23:17], buffer_offset[37:24],
  // rx_store_kind[39:38], rx_store_offset[53:40], recovery_req[54],
  // status[56:55], zeros above
  output logic [bots_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [bots_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bots_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  bots_pkg::cfg_t    cfg;
  bots_pkg::event_t  ev_in, ev_q;
  bots_pkg::result_t res, res_q;
  logic              ev_valid;
  logic              out_ready;
  logic              fire;

  assign ev_in.req_type = s_axis_tuser;
  assign ev_in.answer   = s_axis_tdata[2:0];
  assign fire           = ev_valid && out_ready;

  bots_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bots_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .event_i (ev_in),
    .valid_o (ev_valid),
    .take_i  (fire),
    .event_o (ev_q)
  );

  bots_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .event_i  (ev_q),
    .result_o (res)
  );

  bots_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ev_valid),
    .result_i (res),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .result_o (res_q)
  );

  assign m_axis_tdata = {{(bots_pkg::OutTdataW - $bits(bots_pkg::result_t)){1'b0}}, res_q};

endmodule

// ===== test/bots_checker.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport sequencer result checker
// Watches the event, result and register write channels of the sequencer,
// keeps its own copy of the transfer state and registers, predicts one result
// per accepted event and compares every result transfer against the oldest
// prediction. Also holds the event and result codes shared with the test top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package bots_tb_pkg;

  typedef enum logic [1:0] {REQ_START, REQ_ANSWER, REQ_DETACH, REQ_UNKNOWN} req_e;

  typedef enum logic [2:0] {
    ANS_ACK, ANS_NAK, ANS_STALL, ANS_DATA0, ANS_DATA1, ANS_OTHER, ANS_CODE6, ANS_CODE7
  } answer_e;

  typedef enum logic [2:0] {
    REG_DEVICE_ADDRESS, REG_OUT_ENDPOINT, REG_IN_ENDPOINT, REG_DATA_STAGES,
    REG_STAGE_BYTES, REG_DIRECTION_IN, REG_SPARE_6, REG_SPARE_7
  } reg_e;

  typedef enum logic [1:0] {ACT_NONE, ACT_OUT, ACT_IN} action_e;
  typedef enum logic [1:0] {PID_DATA0, PID_DATA1, PID_IN} pid_e;
  typedef enum logic [1:0] {PH_CBW, PH_DATA, PH_CSW} phase_e;
  typedef enum logic [1:0] {RX_NONE, RX_DATA, RX_CSW} rx_kind_e;
  typedef enum logic [1:0] {ST_BUSY, ST_DONE, ST_FAIL} status_e;

  localparam logic [6:0] CbwBytes = 7'd31;
  localparam logic [6:0] CswBytes = 7'd13;

endpackage

module bots_checker
  import bots_pkg::*, bots_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ev_valid_i,
  input  logic                 ev_ready_i,
  input  logic [InTdataW-1:0]  ev_tdata_i,
  input  logic [InTuserW-1:0]  ev_tuser_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [OutTdataW-1:0] res_tdata_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT_CBW, S_WAIT_DATA, S_WAIT_CSW, S_COMPLETE, S_ERROR
  } xfer_state_e;

  cfg_t        regs;
  xfer_state_e xfer_state;
  logic        out_toggle;
  logic [7:0]  stages_left;
  logic [13:0] data_offset;
  result_t     res;
  result_t     want;
  result_t     got;
  result_t     results_q[$];

  function automatic logic [6:0] packet_len();
    return (regs.stage_bytes > MaxPacketBytes) ? 7'(MaxPacketBytes) : regs.stage_bytes;
  endfunction

  function automatic void issue_cbw();
    stages_left        = regs.data_stages;
    data_offset        = '0;
    res.action         = ACT_OUT;
    res.token_pid      = out_toggle ? PID_DATA1 : PID_DATA0;
    res.endpoint       = regs.out_endpoint;
    res.target_address = regs.device_address;
    res.phase          = PH_CBW;
    res.byte_count     = CbwBytes;
    res.buffer_offset  = '0;
    xfer_state         = S_WAIT_CBW;
  endfunction

  function automatic void issue_data();
    if (regs.direction_in) begin
      res.action    = ACT_IN;
      res.token_pid = PID_IN;
      res.endpoint  = regs.in_endpoint;
    end else begin
      res.action    = ACT_OUT;
      res.token_pid = out_toggle ? PID_DATA1 : PID_DATA0;
      res.endpoint  = regs.out_endpoint;
    end
    res.target_address = regs.device_address;
    res.phase          = PH_DATA;
    res.byte_count     = packet_len();
    res.buffer_offset  = data_offset;
    xfer_state         = S_WAIT_DATA;
  endfunction

  function automatic void issue_csw();
    res.action         = ACT_IN;
    res.token_pid      = PID_IN;
    res.endpoint       = regs.in_endpoint;
    res.target_address = regs.device_address;
    res.phase          = PH_CSW;
    res.byte_count     = CswBytes;
    res.buffer_offset  = '0;
    xfer_state         = S_WAIT_CSW;
  endfunction

  function automatic void next_stage();
    data_offset = data_offset + 14'(packet_len());
    if (stages_left > 8'd1) begin
      stages_left = stages_left - 8'd1;
      issue_data();
    end else begin
      issue_csw();
    end
  endfunction

  function automatic result_t predict_event(req_e req, answer_e ans);
    logic got_data;
    logic active;
    res      = '0;
    got_data = (ans == ANS_DATA0) || (ans == ANS_DATA1);
    active   = (xfer_state == S_WAIT_CBW) || (xfer_state == S_WAIT_DATA) ||
               (xfer_state == S_WAIT_CSW);
    case (req)
      REQ_START: issue_cbw();
      REQ_ANSWER: begin
        if (ans == ANS_STALL && active) begin
          res.recovery_req = 1'b1;
          issue_cbw();
        end else begin
          case (xfer_state)
            S_WAIT_CBW: begin
              if (ans == ANS_ACK) begin
                out_toggle = ~out_toggle;
                if (stages_left == 8'd0) issue_csw();
                else issue_data();
              end else begin
                issue_cbw();
              end
            end
            S_WAIT_DATA: begin
              if (ans == ANS_ACK) begin
                if (regs.direction_in) begin
                  issue_cbw();
                end else begin
                  out_toggle = ~out_toggle;
                  next_stage();
                end
              end else if (got_data) begin
                if (regs.direction_in) begin
                  res.rx_store_kind   = RX_DATA;
                  res.rx_store_offset = data_offset;
                  next_stage();
                end else begin
                  issue_cbw();
                end
              end else begin
                issue_data();
              end
            end
            S_WAIT_CSW: begin
              if (got_data) begin
                res.rx_store_kind = RX_CSW;
                xfer_state        = S_COMPLETE;
              end else begin
                issue_csw();
              end
            end
            default: ;
          endcase
        end
      end
      REQ_DETACH: xfer_state = S_ERROR;
      default: ;
    endcase
    case (xfer_state)
      S_COMPLETE: res.status = ST_DONE;
      S_ERROR:    res.status = ST_FAIL;
      default:    res.status = ST_BUSY;
    endcase
    return res;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf({"act=%0d pid=%0d ep=%0d addr=%0d ph=%0d bytes=%0d boff=%0d",
                      " rxk=%0d rxoff=%0d rr=%0d st=%0d"},
                     r.action, r.token_pid, r.endpoint, r.target_address, r.phase,
                     r.byte_count, r.buffer_offset, r.rx_store_kind, r.rx_store_offset,
                     r.recovery_req, r.status);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs        = '0;
      xfer_state  = S_IDLE;
      out_toggle  = 1'b0;
      stages_left = '0;
      data_offset = '0;
      results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_DEVICE_ADDRESS: regs.device_address = cfg_wdata_i[6:0];
          REG_OUT_ENDPOINT:   regs.out_endpoint   = cfg_wdata_i[3:0];
          REG_IN_ENDPOINT:    regs.in_endpoint    = cfg_wdata_i[3:0];
          REG_DATA_STAGES:    regs.data_stages    = cfg_wdata_i[7:0];
          REG_STAGE_BYTES:    regs.stage_bytes    = cfg_wdata_i[6:0];
          REG_DIRECTION_IN:   regs.direction_in   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (ev_valid_i && ev_ready_i) begin
        results_q.push_back(predict_event(req_e'(ev_tuser_i[1:0]),
                                          answer_e'(ev_tdata_i[2:0])));
      end
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_tdata_i[$bits(result_t)-1:0]);
        if (results_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) begin
            $display("%0t: result transfer with none expected: %s", $time, describe(got));
          end
        end else begin
          want = results_q.pop_front();
          if (res_tdata_i != {{(OutTdataW - $bits(result_t)){1'b0}}, want}) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s pad=%0h", describe(got),
                       res_tdata_i[OutTdataW-1:$bits(result_t)]);
            end
          end
        end
      end
    end
    pending_o = results_q.size();
  end

endmodule

// ===== test/tb_bulk_only_transport_sequencer.sv =====
// ----------------------------------------------------------------------------
// Bulk-only transport sequencer testbench
// Drives start, handshake-answer and detach events into the sequencer in
// random bursts while the result side stalls on its own pattern. A short
// directed sequence walks both transfer directions and every recovery path,
// then register settings change between phases of well-formed transfers with
// random noise. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bulk_only_transport_sequencer;
  import bots_pkg::*;
  import bots_tb_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned LongStall  = 300;
  localparam int          NumPhases  = 8;
  localparam int          PhaseItems = 50;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} rdy_mode_e;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 s_tvalid   = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata    = '0;
  logic [InTuserW-1:0]  s_tuser    = '0;
  logic                 m_tvalid;
  logic                 m_tready   = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx    = '0;
  logic [CfgDataW-1:0]  cfg_wdata  = '0;
  int unsigned          pending;
  int unsigned          fail_count;
  int unsigned          idle_cycles = 0;
  int                   burst_left  = 0;
  bit                   long_stall_req = 1'b0;

  always #1 clk = ~clk;

  bulk_only_transport_sequencer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  bots_checker result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .ev_valid_i   (s_tvalid),
    .ev_ready_i   (s_tready),
    .ev_tdata_i   (s_tdata),
    .ev_tuser_i   (s_tuser),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_tdata_i  (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : result_side
    rdy_mode_e mode = RDY_ALWAYS;
    int        span = 0;
    bit        stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req && !stall_done) begin
        m_tready <= 1'b0;
        repeat (LongStall) @(negedge clk);
        stall_done = 1'b1;
      end
      if (span == 0) begin
        mode = rdy_mode_e'($urandom_range(0, 3));
        span = $urandom_range(16, 96);
      end
      span = span - 1;
      case (mode)
        RDY_ALWAYS:   m_tready <= 1'b1;
        RDY_COIN:     m_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
        default:      m_tready <= span[2];
      endcase
    end
  end

  task automatic send_event(req_e req, answer_e ans);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= InTdataW'(ans);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
  endtask

  task automatic apply_setting(cfg_t c);
    write_reg(REG_DEVICE_ADDRESS, {1'($urandom_range(0, 1)), c.device_address});
    write_reg(REG_OUT_ENDPOINT, CfgDataW'(c.out_endpoint));
    write_reg(REG_IN_ENDPOINT, CfgDataW'(c.in_endpoint));
    write_reg(REG_DATA_STAGES, c.data_stages);
    write_reg(REG_STAGE_BYTES, CfgDataW'(c.stage_bytes));
    write_reg(REG_DIRECTION_IN, CfgDataW'(c.direction_in));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic answer_e data_pid();
    return $urandom_range(0, 1) ? ANS_DATA1 : ANS_DATA0;
  endfunction

  function automatic answer_e any_answer();
    return answer_e'($urandom_range(0, 7));
  endfunction

  // Walks transfers along the good path, tracking which stage is outstanding
  // so that most answers fit, and mixes in repeats, stalls, restarts and noise.
  task automatic run_transfers(cfg_t c, int count);
    int      stage;
    int      last;
    int      roll;
    answer_e good;
    stage = -1;
    last  = int'(c.data_stages) + 1;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (stage < 0 || stage > last) begin
        if (roll < 20) begin
          send_event(REQ_ANSWER, any_answer());
        end else begin
          send_event(REQ_START, any_answer());
          stage = 0;
        end
      end else begin
        if (stage == 0) good = ANS_ACK;
        else if (stage == last || c.direction_in) good = data_pid();
        else good = ANS_ACK;
        if (roll < 70) begin
          send_event(REQ_ANSWER, good);
          stage = stage + 1;
        end else if (roll < 80) begin
          send_event(REQ_ANSWER, ANS_NAK);
        end else if (roll < 85) begin
          send_event(REQ_ANSWER, answer_e'($urandom_range(5, 7)));
        end else if (roll < 89) begin
          send_event(REQ_ANSWER, ANS_STALL);
          stage = 0;
        end else if (roll < 93) begin
          if (stage == 0) begin
            send_event(REQ_ANSWER, data_pid());
          end else if (stage == last) begin
            send_event(REQ_ANSWER, ANS_ACK);
          end else begin
            send_event(REQ_ANSWER, c.direction_in ? ANS_ACK : data_pid());
            stage = 0;
          end
        end else if (roll < 96) begin
          send_event(REQ_START, any_answer());
          stage = 0;
        end else if (roll < 98) begin
          send_event(REQ_DETACH, any_answer());
          stage = -1;
        end else begin
          send_event(REQ_UNKNOWN, any_answer());
        end
      end
    end
  endtask

  initial begin : stimulus
    cfg_t cur;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Write transfer, two stages of a full packet, every recovery path.
    write_reg(REG_SPARE_6, 8'hFF);
    write_reg(REG_SPARE_7, 8'hA5);
    apply_setting({7'h7F, 4'hF, 4'h0, 8'd2, 7'd64, 1'b0});
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_UNKNOWN, ANS_CODE7);
    send_event(REQ_START, ANS_ACK);
    send_event(REQ_ANSWER, ANS_NAK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_NAK);
    send_event(REQ_ANSWER, ANS_CODE6);
    send_event(REQ_ANSWER, ANS_DATA0);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_DATA1);
    send_event(REQ_ANSWER, ANS_NAK);
    send_event(REQ_START, ANS_OTHER);
    send_event(REQ_ANSWER, ANS_STALL);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_STALL);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_STALL);
    send_event(REQ_DETACH, ANS_STALL);
    send_event(REQ_ANSWER, ANS_ACK);
    wait_idle();

    // Read transfer with an oversized packet length.
    apply_setting({7'h00, 4'h0, 4'hF, 8'd2, 7'd127, 1'b1});
    send_event(REQ_START, ANS_DATA1);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_DATA0);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_ACK);
    send_event(REQ_ANSWER, ANS_DATA1);
    send_event(REQ_ANSWER, ANS_OTHER);
    send_event(REQ_ANSWER, ANS_DATA0);
    send_event(REQ_ANSWER, ANS_DATA0);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: cur = {7'h7F, 4'hF, 4'hF, 8'hFF, 7'h7F, 1'b1};
        1: cur = '0;
        default: begin
          cur.device_address = 7'($urandom_range(0, 127));
          cur.out_endpoint   = 4'($urandom_range(0, 15));
          cur.in_endpoint    = 4'($urandom_range(0, 15));
          cur.data_stages    = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 4));
          cur.stage_bytes    = 7'($urandom_range(0, 127));
          cur.direction_in   = 1'($urandom_range(0, 1));
        end
      endcase
      apply_setting(cur);
      if (p == 3) long_stall_req = 1'b1;
      run_transfers(cur, PhaseItems);
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== bulk_only_transport_sequencer.f =====
rtl/bots_pkg.sv
rtl/bots_cfg.sv
rtl/bots_in_reg.sv
rtl/bots_core.sv
rtl/bots_out_reg.sv
rtl/bulk_only_transport_sequencer.sv
test/bots_checker.sv
test/tb_bulk_only_transport_sequencer.sv
